>>> design/uf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and codes for the union-find engine.
// No dependencies; imported by the top level and the checker.

package uf_pkg;

    localparam int NODES_DEF   = 1024;
    localparam int NODE_W      = 10;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic {
        FUNC_UNITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

>>> design/union_find_engine_top.sv
`timescale 1ns / 1ps
// A find walks parent links to the root, then points each non-root entry on the path at it; a node
// beyond the table is its own root. A unite runs two finds and links root_a to root_b; a query
// runs two finds, then loads the result. One item at a time; the parent-table RAM does one read
// and one write a cycle. A unite naming a node beyond the table is dropped in its accept cycle.
// Reset: asynchronous, active low; afterwards a clearing pass writes the identity into every
// entry of the parent table, and no transaction is accepted until it ends.

module union_find_engine_top
    import uf_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // node_a [9:0], node_b [19:10], zero fill [23:20]
    input  logic [0:0]             s_tuser,  // func [0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // connected [0], root_a [10:1], zero fill [15:11]
);

    localparam int AW = $clog2(NODES);
    localparam logic [20:0] NODES_LIM = 21'(NODES);
    localparam logic [AW-1:0] CLR_LAST = AW'(NODES - 1);

    typedef enum logic [6:0] {
        ST_CLEAR      = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_FIND_START = 7'b0000100,
        ST_WALK       = 7'b0001000,
        ST_COMP       = 7'b0010000,
        ST_FIND_DONE  = 7'b0100000,
        ST_RESULT     = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                sel_reg, sel_next;
    func_t               func_reg, func_next;
    logic [NODE_W-1:0]   a_reg, a_next;
    logic [NODE_W-1:0]   b_reg, b_next;
    logic [NODE_W-1:0]   r_reg, r_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   ra_reg, ra_next;
    logic                out_valid_reg, out_valid_next;
    logic                conn_reg, conn_next;
    logic [NODE_W-1:0]   root_reg, root_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [NODE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [NODE_W-1:0]   ram_rdata;

    logic [NODE_W-1:0]   in_a;
    logic [NODE_W-1:0]   in_b;
    logic [NODE_W-1:0]   v;
    logic                v_in;
    logic                in_a_ok;
    logic                in_b_ok;

    uf_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_parent_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_a    = s_tdata[NODE_W-1:0];
    assign in_b    = s_tdata[2*NODE_W-1:NODE_W];
    assign in_a_ok = {11'b0, in_a} < NODES_LIM;
    assign in_b_ok = {11'b0, in_b} < NODES_LIM;
    assign v       = sel_reg ? b_reg : a_reg;
    assign v_in    = {11'b0, v} < NODES_LIM;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        sel_next       = sel_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        cur_next       = cur_reg;
        ra_next        = ra_reg;
        conn_next      = conn_reg;
        root_next      = root_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(cur_reg);
        ram_wdata      = r_reg;
        ram_re         = 1'b0;
        ram_raddr      = AW'(v);
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = NODE_W'(clr_cnt_reg);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    func_next = func_t'(s_tuser[0]);
                    a_next    = in_a;
                    b_next    = in_b;
                    sel_next  = 1'b0;
                    if (!(func_t'(s_tuser[0]) == FUNC_UNITE && !(in_a_ok && in_b_ok)))
                    begin
                        state_next = ST_FIND_START;
                    end
                end
            end
            ST_FIND_START:
            begin
                r_next = v;
                if (v_in)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(v);
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_FIND_DONE;
                end
            end
            ST_WALK:
            begin
                if (ram_rdata == r_reg)
                begin
                    if (v == r_reg)
                    begin
                        state_next = ST_FIND_DONE;
                    end
                    else
                    begin
                        cur_next   = v;
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(v);
                        state_next = ST_COMP;
                    end
                end
                else
                begin
                    r_next    = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ram_rdata);
                end
            end
            ST_COMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(cur_reg);
                ram_wdata = r_reg;
                if (ram_rdata == r_reg)
                begin
                    state_next = ST_FIND_DONE;
                end
                else
                begin
                    cur_next  = ram_rdata;
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ram_rdata);
                end
            end
            ST_FIND_DONE:
            begin
                if (!sel_reg)
                begin
                    ra_next    = r_reg;
                    sel_next   = 1'b1;
                    state_next = ST_FIND_START;
                end
                else if (func_reg == FUNC_UNITE)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(ra_reg);
                    ram_wdata  = r_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    conn_next      = (ra_reg == r_reg);
                    root_next      = ra_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        r_reg    <= r_next;
        cur_reg  <= cur_next;
        ra_reg   <= ra_next;
        conn_reg <= conn_next;
        root_reg <= root_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - NODE_W - 1)'(0), root_reg, conn_reg};

endmodule

>>> design/uf_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port and one registered read port.
// Standalone; used by the union-find top level for the parent table.

module uf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/uf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the union-find engine, bound to the top level.
// Depends on uf_pkg and on the port list of union_find_engine_top.

module uf_checker
    import uf_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [0:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result must hold its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A query transaction always keeps the engine busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == FUNC_QUERY) |=> !s_tready)
        else $error("engine ready right after accepting a query");

    // A new result only appears right after the engine was busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a finished query");

    // Zero fill of the result must stay clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:NODE_W+1] == '0)
        else $error("nonzero fill bits in result");

endmodule

bind union_find_engine_top uf_checker u_uf_checker (.*);
